### rtl/ballistic_coef_atmos_correct_top_assert.svh
// Assertion macros used by the checker of the corrected coefficient block.
`ifndef BALLISTIC_COEF_ATMOS_CORRECT_TOP_ASSERT_SVH
`define BALLISTIC_COEF_ATMOS_CORRECT_TOP_ASSERT_SVH
// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define BCAC_AST_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);
// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define BCAC_AST_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);
`endif

### rtl/bcac_pkg.sv
// Package of constants, types and helpers for the corrected coefficient block.
`timescale 1ns / 1ps
package bcac_pkg;

	localparam int FRAC_BITS_DEF = 24;
	localparam int QW = 62;
	localparam int MUL_LAT = 5;

	localparam logic [QW-1:0] SAT_Q = QW'(1) << 61;
	localparam logic [15:0] OUT_MAX = 16'hFFFF;

	localparam logic [49:0] K_DA0 = 50'd1000000000000000;
	localparam logic [34:0] K_DA1 = 35'd30000000000;
	localparam logic [18:0] K_DA2 = 19'd400000;
	localparam logic [22:0] K_DT0 = 23'd5186000;
	localparam logic [27:0] K_V0 = 28'd251700000;
	localparam logic [21:0] K_V1 = 22'd2340000;
	localparam logic [11:0] K_V2 = 12'd4000;
	localparam logic [11:0] K_VH = 12'd3783;
	localparam logic [46:0] K_PD = 47'd100000000000000;
	localparam logic [46:0] K_PR = 47'd99500000000000;
	localparam logic [11:0] P_STD = 12'd2992;
	localparam logic [10:0] P_HALF = 11'd1496;
	// Reciprocal of 187 scaled by 2^28, rounded up; exact for dividends below 2^20.
	localparam logic [20:0] K_R187 = 21'd1435484;

	typedef struct packed {
		logic        vld;
		logic [14:0] base;
		logic        dr_bad;
		logic        nt_neg;
		logic        pn_neg;
		logic        s_neg;
		logic        zr;
		logic [12:0] pnm;
	} bcac_side_t;

	// Rounds a wide product back to the fixed format and holds it at the ceiling.
	function automatic logic [QW-1:0] rnd_clamp(input logic [127:0] m, input int f);
		logic [128:0] t;
		t = {1'b0, m} + (129'(1) << (f - 1));
		t = t >> f;
		return (t > 129'(SAT_Q)) ? SAT_Q : t[QW-1:0];
	endfunction

endpackage

### rtl/ballistic_coef_atmos_correct_top.sv
// Top level of the atmospheric correction of a ballistic coefficient.
`timescale 1ns / 1ps
// Usage
// The input channel (item_valid / item_ready) carries one word of shooting
// conditions: the standard coefficient, altitude, pressure, temperature and
// humidity. The output channel (res_valid / res_ready) returns one word, the
// corrected coefficient times 10000, saturated at 65535.
// Every input word gives exactly one result word, in order. Words are
// independent, so a new word is taken in every cycle while the output moves.
// The three long divisions each run as a chain of 60 + FRAC_BITS stages,
// one quotient bit per stage, and the later 64 by 64 products each take five
// stages of 32 by 32 multipliers.
// The pressure factor divides by a constant and is formed by a reciprocal
// multiplication in the last stages before the divider outputs.
// Throughput is one word per cycle while the output is not stalled.
// When the receiver holds res_ready low with a result waiting, the whole
// pipeline freezes and item_ready drops in the same cycle; nothing is lost or
// repeated, and flow resumes as soon as res_ready returns.
// The asynchronous reset clears every valid bit, so the pipeline comes up
// empty; no state survives between words.
module ballistic_coef_atmos_correct_top import bcac_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [14:0]        base_coef,
	input  logic [14:0]        altitude_ft,
	input  logic [11:0]        pressure_centi_inhg,
	input  logic signed [11:0] temp_deci_f,
	input  logic [9:0]         humidity_permille,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [15:0]        corrected_coef
);

	// Numerator width shared by all three dividers, so they line up in time.
	localparam int NWD    = 60 + FRAC_BITS;
	localparam int ST_NUM = 7;
	localparam int ST_DIV = ST_NUM + NWD;
	localparam int ST_CLP = ST_DIV + 1;
	localparam int ST_SS  = ST_CLP + 1;
	localparam int ST_M1  = ST_SS + MUL_LAT;
	localparam int ST_R1  = ST_M1 + 1;
	localparam int ST_M2  = ST_R1 + MUL_LAT;
	localparam int ST_R2  = ST_M2 + 1;
	localparam int ST_M3  = ST_R2 + MUL_LAT;
	localparam int ST_OUT = ST_M3 + 1;

	// The scale 2^FRAC_BITS split as a multiple of 2992 plus a remainder.
	localparam logic [NWD-1:0] FP_QC = NWD'((64'd1 << FRAC_BITS) / 64'(P_STD));
	localparam logic [11:0]    FP_RC = 12'((64'd1 << FRAC_BITS) % 64'(P_STD));

	// The pipeline advances as one; it only stops when the output word waits.
	logic adv;
	bcac_side_t side_s [1:ST_OUT];

	assign res_valid  = side_s[ST_OUT].vld;
	assign adv        = !res_valid || res_ready;
	assign item_ready = adv;

	// Front end: polynomial terms of altitude and temperature, pressure and humidity products.
	logic [14:0]        a_s1, a_s2;
	logic [11:0]        p_s1, p_s2;
	logic signed [11:0] x_s1, x_s2;
	logic [9:0]         h_s1;
	logic [29:0]        a2_s2;
	logic [22:0]        x2_s2;
	logic [21:0]        hk_s2, hk_s3, hk_s4;
	logic signed [23:0] nt_s2, nt_s3, nt_s4, nt_s5, nt_s6;
	logic [22:0]        dt_s2, dt_s3, dt_s4, dt_s5, dt_s6, dt_s7;
	logic signed [12:0] pn_s2, pn_s3, pn_s4, pn_s5, pn_s6;
	logic [44:0]        a3_s3;
	logic [49:0]        t1_s3;
	logic [48:0]        t2_s3;
	logic signed [35:0] x3_s3;
	logic [34:0]        v2_s3;
	logic signed [33:0] v1_s3;
	logic [58:0]        pk_s3, pk_s4, pk_s5;
	logic [58:0]        pr_s3, pr_s4, pr_s5, pr_s6;
	logic [49:0]        da_s4, da_s5, da_s6, da_s7;
	logic signed [39:0] v_s4;
	logic signed [61:0] hv_s5;
	logic signed [61:0] dr_s6;
	logic [59:0]        dr_s7;
	logic [NWD-1:0]     nfa_s7, nft_s7, nfr_s7;

	logic signed [23:0] ntw;
	logic signed [52:0] daw;
	logic signed [39:0] vw;
	logic [23:0]        ntm;
	logic [12:0]        pnm;
	logic               dr_bad_w;

	always_comb begin
		ntw = (24'(x_s1) * 24'sd1000) - 24'sd590000 + ($signed({9'd0, a_s1}) * 24'sd36);
		daw = $signed(53'(K_DA0)) - $signed(53'(t1_s3)) + $signed(53'(t2_s3))
			- $signed(53'({a3_s3, 2'b00}));
		vw  = (40'(x3_s3) * 40'sd4) - $signed(40'(v2_s3)) + 40'(v1_s3)
			- $signed(40'(K_V0));
		ntm = nt_s6[23] ? 24'(-nt_s6) : 24'(nt_s6);
		pnm = pn_s6[12] ? 13'(-pn_s6) : 13'(pn_s6);
		// A humidity denominator of zero or below means an unbounded factor.
		dr_bad_w = dr_s6[61] || (dr_s6 == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= altitude_ft;
			p_s1  <= pressure_centi_inhg;
			x_s1  <= temp_deci_f;
			h_s1  <= humidity_permille;

			a_s2  <= a_s1;
			p_s2  <= p_s1;
			x_s2  <= x_s1;
			a2_s2 <= 30'(a_s1) * 30'(a_s1);
			x2_s2 <= 23'(24'(x_s1) * 24'(x_s1));
			hk_s2 <= 22'(h_s1) * 22'(K_VH);
			nt_s2 <= ntw;
			dt_s2 <= K_DT0 - 23'(a_s1) * 23'd36;
			pn_s2 <= $signed({1'b0, p_s1}) - $signed({1'b0, P_STD});

			a3_s3 <= 45'(a2_s2) * 45'(a_s2);
			t1_s3 <= 50'(a_s2) * 50'(K_DA1);
			t2_s3 <= 49'(a2_s2) * 49'(K_DA2);
			x3_s3 <= $signed({13'd0, x2_s2}) * 36'(x_s2);
			v2_s3 <= 35'(x2_s2) * 35'(K_V2);
			v1_s3 <= 34'(x_s2) * $signed(34'(K_V1));
			pk_s3 <= 59'(p_s2) * 59'(K_PD);
			pr_s3 <= 59'(p_s2) * 59'(K_PR);
			hk_s3 <= hk_s2;
			nt_s3 <= nt_s2;
			dt_s3 <= dt_s2;
			pn_s3 <= pn_s2;

			da_s4 <= daw[49:0];
			v_s4  <= vw;
			pk_s4 <= pk_s3;
			pr_s4 <= pr_s3;
			hk_s4 <= hk_s3;
			nt_s4 <= nt_s3;
			dt_s4 <= dt_s3;
			pn_s4 <= pn_s3;

			hv_s5 <= $signed(62'(hk_s4)) * 62'(v_s4);
			pk_s5 <= pk_s4;
			pr_s5 <= pr_s4;
			da_s5 <= da_s4;
			nt_s5 <= nt_s4;
			dt_s5 <= dt_s4;
			pn_s5 <= pn_s4;

			dr_s6 <= $signed(62'(pk_s5)) - hv_s5;
			pr_s6 <= pr_s5;
			da_s6 <= da_s5;
			nt_s6 <= nt_s5;
			dt_s6 <= dt_s5;
			pn_s6 <= pn_s5;

			// Half the divisor is added so that the divider rounds to nearest.
			nfa_s7 <= (NWD'(K_DA0) << FRAC_BITS) + NWD'(da_s6 >> 1);
			nft_s7 <= (NWD'(ntm) << FRAC_BITS) + NWD'(dt_s6 >> 1);
			nfr_s7 <= (NWD'(pr_s6) << FRAC_BITS) + NWD'(dr_s6[60:1]);
			da_s7  <= da_s6;
			dt_s7  <= dt_s6;
			dr_s7  <= dr_s6[59:0];
		end
	end

	// The four factors as rounded quotients.
	logic [NWD-1:0] qfa, qft, qfp, qfr;

	bcac_div #(.NW(NWD), .DW(50)) u_div_fa (
		.clk(clk), .en(adv), .num(nfa_s7), .den(da_s7), .quo(qfa)
	);
	bcac_div #(.NW(NWD), .DW(23)) u_div_ft (
		.clk(clk), .en(adv), .num(nft_s7), .den(dt_s7), .quo(qft)
	);
	bcac_div #(.NW(NWD), .DW(60)) u_div_fr (
		.clk(clk), .en(adv), .num(nfr_s7), .den(dr_s7), .quo(qfr)
	);

	// The pressure factor divides by 2992, so it needs no divider. With
	// 2^FRAC_BITS = 2992 * FP_QC + FP_RC the rounded quotient is
	// pnm * FP_QC plus (pnm * FP_RC + 1496) / 2992, and the small division is a
	// shift by four and a multiplication by the reciprocal of 187. The magnitude
	// rides in the side band and the three stages end level with the dividers.
	logic [23:0]    fpy_sp1;
	logic [NWD-1:0] fph_sp1, fph_sp2;
	logic [11:0]    fpq_sp2;

	always_ff @(posedge clk) begin
		if (adv) begin
			fpy_sp1 <= 24'(side_s[ST_DIV-3].pnm) * 24'(FP_RC) + 24'(P_HALF);
			fph_sp1 <= NWD'(side_s[ST_DIV-3].pnm) * FP_QC;

			fpq_sp2 <= 12'((41'(fpy_sp1[23:4]) * 41'(K_R187)) >> 28);
			fph_sp2 <= fph_sp1;

			qfp     <= fph_sp2 + NWD'(fpq_sp2);
		end
	end

	// Clamp stage, then the sum 1 + FT - FP, which is exact in the format.
	logic [QW-1:0]      fa_sc, fr_sc, fa_ss, fr_ss;
	logic signed [63:0] ft_sc, fp_sc;
	logic [63:0]        smag_ss;
	logic [QW-1:0]      cft, cfp;
	logic signed [63:0] sw;

	always_comb begin
		cft = (qft > NWD'(SAT_Q)) ? SAT_Q : qft[QW-1:0];
		cfp = (qfp > NWD'(SAT_Q)) ? SAT_Q : qfp[QW-1:0];
		sw  = $signed(64'(1) << FRAC_BITS) + ft_sc - fp_sc;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fa_sc   <= (qfa > NWD'(SAT_Q)) ? SAT_Q : qfa[QW-1:0];
			fr_sc   <= (qfr > NWD'(SAT_Q)) ? SAT_Q : qfr[QW-1:0];
			ft_sc   <= side_s[ST_DIV].nt_neg ? -$signed(64'(cft)) : $signed(64'(cft));
			fp_sc   <= side_s[ST_DIV].pn_neg ? -$signed(64'(cfp)) : $signed(64'(cfp));

			fa_ss   <= fa_sc;
			fr_ss   <= fr_sc;
			smag_ss <= sw[63] ? 64'(-sw) : 64'(sw);
		end
	end

	// FA times the sum, then times FR, then the coefficient itself.
	logic [127:0]  m1, m2, m3;
	logic [QW-1:0] fr_sd [1:MUL_LAT];
	logic [QW-1:0] fr_sr1, p1_sr1, p2_sr2, p2w;
	logic [128:0]  fin;
	logic [15:0]   coef_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_sd[1] <= fr_ss;
			for (int j = 2; j <= MUL_LAT; j++) begin
				fr_sd[j] <= fr_sd[j-1];
			end
		end
	end

	bcac_mul64 u_mul_fs (
		.clk(clk), .en(adv), .a(64'(fa_ss)), .b(smag_ss), .p(m1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_sr1 <= rnd_clamp(m1, FRAC_BITS);
			fr_sr1 <= fr_sd[MUL_LAT];
		end
	end

	bcac_mul64 u_mul_fr (
		.clk(clk), .en(adv), .a(64'(p1_sr1)), .b(64'(fr_sr1)), .p(m2)
	);

	assign p2w = rnd_clamp(m2, FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_sr2 <= p2w;
		end
	end

	bcac_mul64 u_mul_bc (
		.clk(clk), .en(adv), .a(64'(side_s[ST_R2].base)), .b(64'(p2_sr2)), .p(m3)
	);

	// Final rounding (ties up), saturation and the special cases.
	assign fin = ({1'b0, m3} + (129'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s[ST_M3].dr_bad) begin
				coef_q <= (side_s[ST_M3].base != '0) ? OUT_MAX : '0;
			end else if (side_s[ST_M3].zr) begin
				coef_q <= '0;
			end else if (fin > 129'(OUT_MAX)) begin
				coef_q <= OUT_MAX;
			end else begin
				coef_q <= fin[15:0];
			end
		end
	end

	assign corrected_coef = coef_q;

	// Side band: valid bit, coefficient and sign flags travel with the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[1] <= '0;
		end else if (adv) begin
			side_s[1]      <= '0;
			side_s[1].vld  <= item_valid;
			side_s[1].base <= base_coef;
		end
	end

	for (genvar k = 2; k <= ST_OUT; k++) begin : g_side
		bcac_side_t nx;

		always_comb begin
			nx = side_s[k-1];
			if (k == ST_NUM) begin
				nx.dr_bad = dr_bad_w;
				nx.nt_neg = nt_s6[23];
				nx.pn_neg = pn_s6[12];
				nx.pnm    = pnm;
			end
			if (k == ST_SS) begin
				nx.s_neg = sw[63];
			end
			// A product that is zero or negative gives a zero result.
			if (k == ST_R2) begin
				nx.zr = side_s[k-1].s_neg || (p2w == '0);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (adv) begin
				side_s[k] <= nx;
			end
		end
	end

endmodule

### rtl/bcac_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module bcac_div import bcac_pkg::*; #(
	parameter int NW = 84,
	parameter int DW = 50
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [1:NW];
	logic [NW-1:0] nq_s  [1:NW];
	logic [DW-1:0] den_s [1:NW];

	for (genvar k = 1; k <= NW; k++) begin : g_stg
		logic [DW-1:0] rem_p;
		logic [NW-1:0] nq_p;
		logic [DW-1:0] den_p;
		logic [DW:0]   sh;
		logic [DW+1:0] df;

		if (k == 1) begin : g_first
			assign rem_p = '0;
			assign nq_p  = num;
			assign den_p = den;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign nq_p  = nq_s[k-1];
			assign den_p = den_s[k-1];
		end

		always_comb begin
			sh = {rem_p, nq_p[NW-1]};
			df = {1'b0, sh} - {2'b00, den_p};
		end

		// The partial remainder stays below the divisor, so DW bits hold it.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!df[DW+1]) begin
					rem_s[k] <= df[DW-1:0];
					nq_s[k]  <= {nq_p[NW-2:0], 1'b1};
				end else begin
					rem_s[k] <= sh[DW-1:0];
					nq_s[k]  <= {nq_p[NW-2:0], 1'b0};
				end
				den_s[k] <= den_p;
			end
		end
	end

	assign quo = nq_s[NW];

endmodule

### rtl/bcac_mul64.sv
// Five-stage 64 by 64 unsigned multiplier built from 32 by 32 partial products.
`timescale 1ns / 1ps
module bcac_mul64 import bcac_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] p
);

	logic [63:0]  a_s1, b_s1, a_s2, b_s2, a_s3, b_s3;
	logic [63:0]  pp_s1, pp_s2, pp_s3, pp_s4;
	logic [127:0] acc_s2, acc_s3, acc_s4, acc_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1  <= 64'(a[31:0]) * 64'(b[31:0]);
			a_s1   <= a;
			b_s1   <= b;

			acc_s2 <= 128'(pp_s1);
			pp_s2  <= 64'(a_s1[31:0]) * 64'(b_s1[63:32]);
			a_s2   <= a_s1;
			b_s2   <= b_s1;

			acc_s3 <= acc_s2 + (128'(pp_s2) << 32);
			pp_s3  <= 64'(a_s2[63:32]) * 64'(b_s2[31:0]);
			a_s3   <= a_s2;
			b_s3   <= b_s2;

			acc_s4 <= acc_s3 + (128'(pp_s3) << 32);
			pp_s4  <= 64'(a_s3[63:32]) * 64'(b_s3[63:32]);

			acc_s5 <= acc_s4 + (128'(pp_s4) << 64);
		end
	end

	assign p = acc_s5;

endmodule

### rtl/bcac_chk.sv
// Port-level checker for the corrected coefficient block, bound to the top level.
`timescale 1ns / 1ps
`include "ballistic_coef_atmos_correct_top_assert.svh"
module bcac_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] corrected_coef
);

	logic [8:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = res_valid && res_ready;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 9'(in_acc) - 9'(out_acc);
		end
	end

	`BCAC_AST_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(corrected_coef), "result word changed while stalled")
	`BCAC_AST_NOW(a_ready, 1'b1, item_ready == (!res_valid || res_ready), "input stalled while output free")
	`BCAC_AST_NOW(a_count, res_valid, inflight_q != '0, "result word without an accepted input word")

endmodule

bind ballistic_coef_atmos_correct_top bcac_chk u_chk (.*);

### test/tb_top.sv
// Self-checking testbench of the atmospheric correction of a ballistic coefficient.
`timescale 1ns / 1ps
module tb_top;
	import bcac_pkg::*;

	// One word of shooting conditions, with an optional hand-written expectation.
	typedef struct {
		logic [14:0]        base;
		logic [14:0]        alt;
		logic [11:0]        pres;
		logic signed [11:0] temp;
		logic [9:0]         hum;
		bit                 known;
		logic [15:0]        coef;
	} cond_word_t;

	localparam int N_RANDOM  = 1900;
	localparam int LIMIT_CYC = 400000;
	localparam int DRAIN_CYC = 200;
	localparam int HOLD_CYC  = 600;

	localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS_DEF;
	localparam logic [63:0] CEIL_FX = 64'd1 << 61;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [14:0] base_coef = '0;
	logic [14:0] altitude_ft = '0;
	logic [11:0] pressure_centi_inhg = '0;
	logic signed [11:0] temp_deci_f = '0;
	logic [9:0] humidity_permille = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [15:0] corrected_coef;

	cond_word_t conditions[$];
	logic [15:0] coef_due[$];
	int n_words = 0;
	int n_issued = 0;
	int n_taken = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit stim_ready = 1'b0;

	ballistic_coef_atmos_correct_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.base_coef(base_coef), .altitude_ft(altitude_ft),
		.pressure_centi_inhg(pressure_centi_inhg), .temp_deci_f(temp_deci_f),
		.humidity_permille(humidity_permille),
		.res_valid(res_valid), .res_ready(res_ready), .corrected_coef(corrected_coef)
	);

	always #10 clk = ~clk;

	// The rounded quotient a*b/c, ties upwards, held at the ceiling of the fixed format.
	// A zero divisor, or a quotient that would not fit in 64 bits, also gives the ceiling.
	function automatic logic [63:0] div_round(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [127:0] m;
		logic [127:0] q;
		if (c == 0)
			return CEIL_FX;
		m = 128'(a) * 128'(b) + 128'(c >> 1);
		if ((m >> 64) >= 128'(c))
			return CEIL_FX;
		q = m / 128'(c);
		return (q > 128'(CEIL_FX)) ? CEIL_FX : q[63:0];
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// A signed ratio turned into the fixed format; the rounding works on the magnitude.
	function automatic longint fx_ratio(longint n, longint d);
		longint q;
		q = longint'(div_round(magnitude(n), ONE_FX, 64'(d)));
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint q;
		q = longint'(div_round(magnitude(a), magnitude(b), ONE_FX));
		return ((a < 0) != (b < 0)) ? -q : q;
	endfunction

	// The corrected coefficient: altitude, temperature, pressure and humidity factors.
	function automatic logic [15:0] corrected_of(cond_word_t w);
		longint a, p, x, h, da, nt, dt, vp, dr, fa, ft, fp, fr, s, prod;
		logic [63:0] r;
		a = longint'(w.alt);
		p = longint'(w.pres);
		x = longint'(w.temp);
		h = longint'(w.hum);
		da = 64'sd1000000000000000 - 64'sd30000000000 * a + 64'sd400000 * a * a
			- 64'sd4 * a * a * a;
		fa = longint'(div_round(64'd1000000000000000, ONE_FX, 64'(da)));
		nt = 64'sd1000 * x - 64'sd590000 + 64'sd36 * a;
		dt = 64'sd5186000 - 64'sd36 * a;
		ft = fx_ratio(nt, dt);
		fp = fx_ratio(p - 64'sd2992, 64'sd2992);
		s = longint'(ONE_FX) + ft - fp;
		vp = 64'sd4 * x * x * x - 64'sd4000 * x * x + 64'sd2340000 * x - 64'sd251700000;
		dr = 64'sd100000000000000 * p - 64'sd3783 * h * vp;
		// A vanishing or negative humidity denominator means an unbounded correction.
		if (dr <= 0)
			return (w.base != 0) ? OUT_MAX : 16'd0;
		fr = longint'(div_round(64'd99500000000000 * 64'(p), ONE_FX, 64'(dr)));
		prod = fx_mul(fx_mul(fa, s), fr);
		if (prod <= 0)
			return 16'd0;
		r = div_round(64'(w.base), 64'(prod), ONE_FX);
		return (r > 64'(OUT_MAX)) ? OUT_MAX : r[15:0];
	endfunction

	function automatic cond_word_t cond(int b, int a, int p, int t, int h, bit k, int c);
		cond_word_t w;
		w.base = 15'(b);
		w.alt = 15'(a);
		w.pres = 12'(p);
		w.temp = 12'(t);
		w.hum = 10'(h);
		w.known = k;
		w.coef = 16'(c);
		return w;
	endfunction

	// Directed words first, then random ones. The directed table types in only the
	// answers that are obvious: a zero coefficient, saturation, and the humidity and
	// zero-pressure special cases.
	initial begin
		cond_word_t w;
		int pick;
		conditions.push_back(cond(0, 0, 2992, 590, 0, 1, 0));
		conditions.push_back(cond(0, 32767, 4095, 2047, 1023, 1, 0));
		conditions.push_back(cond(10000, 0, 2992, 590, 0, 0, 0));
		conditions.push_back(cond(20000, 20000, 2000, -400, 1000, 0, 0));
		conditions.push_back(cond(20000, 20000, 3200, 1300, 1000, 0, 0));
		conditions.push_back(cond(32767, 0, 2992, 590, 0, 0, 0));
		conditions.push_back(cond(1, 0, 2992, 590, 0, 0, 0));
		conditions.push_back(cond(32767, 32767, 2992, 590, 0, 1, 65535));
		// Zero pressure with hot humid air leaves the humidity denominator negative.
		conditions.push_back(cond(5000, 0, 0, 1300, 1000, 1, 65535));
		conditions.push_back(cond(0, 0, 0, 1300, 1000, 1, 0));
		// Zero pressure and no humidity: the denominator is exactly zero.
		conditions.push_back(cond(7, 100, 0, 0, 0, 1, 65535));
		// Zero pressure with cold air: the humidity factor and so the output are zero.
		conditions.push_back(cond(15000, 0, 0, 0, 500, 1, 0));
		conditions.push_back(cond(15000, 32767, 1, 2047, 1023, 0, 0));
		conditions.push_back(cond(15000, 0, 4095, -2048, 0, 0, 0));
		conditions.push_back(cond(15000, 32767, 4095, -2048, 1023, 0, 0));
		conditions.push_back(cond(12345, 5000, 2992, -1, 1, 0, 0));
		conditions.push_back(cond(20000, 0, 2000, 2047, 1023, 0, 0));
		conditions.push_back(cond(25000, 10000, 2500, 800, 500, 0, 0));
		conditions.push_back(cond(32767, 0, 4095, -2048, 0, 0, 0));
		conditions.push_back(cond(8000, 16384, 2048, -1024, 512, 0, 0));
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				w = cond($urandom_range(0, 20000), $urandom_range(0, 20000),
					$urandom_range(2000, 3200), $urandom_range(0, 1700) - 400,
					$urandom_range(0, 1000), 0, 0);
			end else begin
				// Whole bit patterns, out of range included.
				w = cond($urandom, $urandom, $urandom, $urandom, $urandom, 0, 0);
			end
			conditions.push_back(w);
		end
		n_words = conditions.size();
		stim_ready = 1'b1;
	end

	// Idling follows the progress of the stimulus: the sender idles with odds of 23
	// in a hundred and the receiver 87, then the other way round, then neither.
	function automatic int phase_now();
		if (n_issued < n_words / 3)
			return 0;
		else if (n_issued < (2 * n_words) / 3)
			return 1;
		return 2;
	endfunction

	// Sender: the next word is offered only once the present one has gone.
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				coef_due.push_back(conditions[n_taken].known ? conditions[n_taken].coef
					: corrected_of(conditions[n_taken]));
				n_taken++;
			end
			if (!item_valid || item_ready) begin
				idle_pct = (phase_now() == 0) ? 23 : (phase_now() == 1) ? 87 : 0;
				if (stim_ready && n_issued < n_words && $urandom_range(0, 99) >= idle_pct) begin
					item_valid <= 1'b1;
					base_coef <= conditions[n_issued].base;
					altitude_ft <= conditions[n_issued].alt;
					pressure_centi_inhg <= conditions[n_issued].pres;
					temp_deci_f <= conditions[n_issued].temp;
					humidity_permille <= conditions[n_issued].hum;
					n_issued++;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word against the oldest expectation. Once, in the
	// last phase, it holds off for a long stretch so that the pipeline freezes and
	// the input stalls while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		logic [15:0] want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (coef_due.size() == 0) begin
					$error("corrected_coef: unexpected result word %0d", corrected_coef);
					n_errors++;
				end else begin
					want = coef_due.pop_front();
					if (corrected_coef !== want) begin
						$error("corrected_coef: expected %0d, got %0d", want, corrected_coef);
						n_errors++;
					end
				end
				n_checked++;
			end
			if (!hold_done && phase_now() == 2) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				idle_pct = (phase_now() == 0) ? 87 : (phase_now() == 1) ? 23 : 0;
				res_ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYC) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				n_cycles, coef_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_ready && n_taken == n_words && coef_due.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (coef_due.size() != 0) begin
			$error("corrected_coef: %0d expected words never arrived", coef_due.size());
			n_errors++;
		end
		$display("Sent %0d condition words (%0d directed), checked %0d results,",
			n_words, n_words - N_RANDOM, n_checked);
		$display("with uneven idling on both sides and one long output stall.");
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
